>>> hdl/sliding_window_event_counter_defines.svh
// ----------------------------------------------------------------------------
// Sliding window event counter: assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EVENT_COUNTER_DEFINES_SVH
`define SLIDING_WINDOW_EVENT_COUNTER_DEFINES_SVH

// Overlapping implication, sampled on i_clk, off while reset is asserted.
`define SWEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define SWEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/swec_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window event counter package
// Shared constants, operation codes, controller states and control structs.
// ----------------------------------------------------------------------------
package swec_pkg;

    localparam int DEF_STORE_DEPTH = 64;
    localparam int DEF_TIME_WIDTH  = 48;
    localparam int WINDOW_WIDTH    = 32;
    localparam int TOTAL_WIDTH     = 32;

    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 32'd5000;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the accepted word
        logic evict;    // drop the oldest stored stamp
        logic finish;   // apply the operation and load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;    // no stamps stored
        logic early;    // time is below the window, nothing can be outdated
        logic outdated; // the oldest stored stamp lies at or below the limit
        logic out_free; // the result register can take a new word
    } t_dp_status;

endpackage

>>> hdl/sliding_window_event_counter.sv
// ----------------------------------------------------------------------------
// Sliding window event counter
// Counts recorded events in total and within a sliding time window.
// ----------------------------------------------------------------------------
// Each input word is either a record (operation 0) or a query (operation 1)
// at time i_now_time, and every word yields exactly one result word. The
// block keeps the stamps of recorded events in a ring of STORE_DEPTH entries.
// Before either operation, the oldest stamps that lie at or below
// now_time - window_ticks are popped one by one; popping stops at the first
// stamp that is still inside the window. A record then adds one to the
// 32-bit total, which wraps, and pushes now_time; if the ring is full, the
// oldest stamp is dropped and o_dropped_flag is raised. The result carries
// the total, the number of stamps left in the ring and the dropped flag,
// which is always 0 for a query. The window register (reset 5000 ticks,
// zero acts as one) is written on the configuration channel, which is
// always ready and must only be used while no word is in flight.
// Timing: one word at a time. A word is loaded, then stays in the check
// state while it pops stamps, because the ring is a single RAM whose
// registered read port examines one oldest stamp per cycle. Each stamp is
// popped at most once after its push. A new word is taken while the previous
// result still waits at the output. The ring needs no clearing after reset:
// only stored entries are read.
// ----------------------------------------------------------------------------
module sliding_window_event_counter #(
    parameter int STORE_DEPTH = swec_pkg::DEF_STORE_DEPTH,
    parameter int TIME_WIDTH  = swec_pkg::DEF_TIME_WIDTH,
    parameter int CW          = $clog2(STORE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input word channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_operation,
    input  logic [TIME_WIDTH-1:0]              i_now_time,
    // Configuration channel: window length in ticks.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [swec_pkg::WINDOW_WIDTH-1:0]  i_window_ticks,
    // Result word channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [swec_pkg::TOTAL_WIDTH-1:0]   o_total_events,
    output logic [CW-1:0]                      o_window_events,
    output logic                               o_dropped_flag
);

    import swec_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The window register can be written in any cycle.
    assign o_cfg_ready = 1'b1;

    swec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    swec_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .CW          (CW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_operation     (i_operation),
        .i_now_time      (i_now_time),
        .i_cfg_valid     (i_cfg_valid),
        .i_window_ticks  (i_window_ticks),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_total_events  (o_total_events),
        .o_window_events (o_window_events),
        .o_dropped_flag  (o_dropped_flag)
    );

endmodule

>>> hdl/swec_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/swec_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window event counter controller
// Accepts a word, steps the eviction loop and finishes the operation.
// ----------------------------------------------------------------------------
module swec_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  swec_pkg::t_dp_status  i_status,
    output swec_pkg::t_dp_cmd     o_cmd
);

    import swec_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // Pop one outdated stamp per cycle, then finish once the
                // result register has room.
                if (!i_status.early && !i_status.empty && i_status.outdated) begin
                    o_cmd.evict = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/swec_dp.sv
// ----------------------------------------------------------------------------
// Sliding window event counter datapath
// Stamp store, ring pointers, window limit, event total and result register.
// ----------------------------------------------------------------------------
module swec_dp #(
    parameter int STORE_DEPTH = swec_pkg::DEF_STORE_DEPTH,
    parameter int TIME_WIDTH  = swec_pkg::DEF_TIME_WIDTH,
    parameter int CW          = $clog2(STORE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  swec_pkg::t_dp_cmd                  i_cmd,
    output swec_pkg::t_dp_status               o_status,
    input  logic                               i_operation,
    input  logic [TIME_WIDTH-1:0]              i_now_time,
    input  logic                               i_cfg_valid,
    input  logic [swec_pkg::WINDOW_WIDTH-1:0]  i_window_ticks,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [swec_pkg::TOTAL_WIDTH-1:0]   o_total_events,
    output logic [CW-1:0]                      o_window_events,
    output logic                               o_dropped_flag
);

    import swec_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LW = (TIME_WIDTH > WINDOW_WIDTH) ? TIME_WIDTH : WINDOW_WIDTH;
    localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_OCC  = CW'(STORE_DEPTH);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
        return (slot == LAST_SLOT) ? '0 : slot + AW'(1);
    endfunction

    logic [WINDOW_WIDTH-1:0] r_window;
    logic [AW-1:0]           r_head;
    logic [AW-1:0]           r_tail;
    logic [CW-1:0]           r_occ;
    logic [TOTAL_WIDTH-1:0]  r_total;
    logic                    r_out_valid;
    logic                    r_op;
    logic [TIME_WIDTH-1:0]   r_now;
    logic [LW-1:0]           r_limit;
    logic                    r_early;
    logic [TOTAL_WIDTH-1:0]  r_out_total;
    logic [CW-1:0]           r_out_count;
    logic                    r_out_dropped;

    logic [AW-1:0]           n_head;
    logic [AW-1:0]           n_tail;
    logic [CW-1:0]           n_occ;
    logic [TOTAL_WIDTH-1:0]  n_total;
    logic                    n_dropped;

    logic [WINDOW_WIDTH-1:0] win_eff;
    logic [LW-1:0]           now_ext;
    logic [LW-1:0]           win_ext;
    logic [AW-1:0]           head_inc;
    logic                    full;
    logic                    is_record;
    logic [AW-1:0]           ram_raddr;
    logic [TIME_WIDTH-1:0]   ram_rdata;

    // A zero window behaves as a window of one tick.
    assign win_eff   = (r_window == '0) ? WINDOW_WIDTH'(1) : r_window;
    assign now_ext   = LW'(i_now_time);
    assign win_ext   = LW'(win_eff);
    assign head_inc  = next_slot(r_head);
    assign full      = (r_occ == FULL_OCC);
    assign is_record = (r_op == OP_RECORD);

    // Look ahead to the next oldest stamp while popping.
    assign ram_raddr = i_cmd.evict ? head_inc : r_head;

    swec_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && is_record),
        .i_waddr (r_tail),
        .i_wdata (r_now),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_status.empty    = (r_occ == '0);
    assign o_status.early    = r_early;
    assign o_status.outdated = (LW'(ram_rdata) <= r_limit);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_total   = r_total;
        n_dropped = 1'b0;
        if (i_cmd.evict) begin
            n_head = head_inc;
            n_occ  = r_occ - CW'(1);
        end else if (i_cmd.finish && is_record) begin
            n_total = r_total + TOTAL_WIDTH'(1);
            n_tail  = next_slot(r_tail);
            if (full) begin
                n_head    = head_inc;
                n_dropped = 1'b1;
            end else begin
                n_occ = r_occ + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_window_ticks;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_total <= n_total;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_now   <= i_now_time;
            r_early <= (now_ext < win_ext);
            r_limit <= now_ext - win_ext;
        end
        if (i_cmd.finish) begin
            r_out_total   <= n_total;
            r_out_count   <= n_occ;
            r_out_dropped <= n_dropped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_total_events  = r_out_total;
    assign o_window_events = r_out_count;
    assign o_dropped_flag  = r_out_dropped;

endmodule

>>> hdl/swec_checker.sv
// ----------------------------------------------------------------------------
// Sliding window event counter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_event_counter_defines.svh"

module swec_checker #(
    parameter int STORE_DEPTH = swec_pkg::DEF_STORE_DEPTH,
    parameter int CW          = $clog2(STORE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic [swec_pkg::TOTAL_WIDTH-1:0]   o_total_events,
    input  logic [CW-1:0]                      o_window_events,
    input  logic                               o_dropped_flag
);

    localparam logic [CW-1:0] FULL_OCC = CW'(STORE_DEPTH);

    // A stalled result word keeps its contents.
    `SWEC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_total_events) && $stable(o_window_events) && $stable(o_dropped_flag), "result word changed while stalled")

    // The reported count never exceeds the ring size.
    `SWEC_ASSERT_NOW(a_count_bound, o_out_valid, o_window_events <= FULL_OCC, "window count exceeds store depth")

    // A drop only happens when the ring is full after the push.
    `SWEC_ASSERT_NOW(a_drop_full, o_out_valid && o_dropped_flag, o_window_events == FULL_OCC, "drop reported without a full store")

    // Words are handled one at a time, so input is not ready right after one.
    `SWEC_ASSERT_NEXT(a_in_gap, i_in_valid && o_in_ready, !o_in_ready, "input ready right after an accepted word")

    // The window register takes a write in any cycle.
    `SWEC_ASSERT_NOW(a_cfg_ready, i_cfg_valid, o_cfg_ready, "configuration channel not ready")

endmodule

bind sliding_window_event_counter swec_checker #(
    .STORE_DEPTH (STORE_DEPTH),
    .CW          (CW)
) u_swec_checker (.*);

>>> test/sliding_window_event_counter_tb.sv
// ----------------------------------------------------------------------------
// Sliding window event counter testbench
// Drives record and query words with random handshake gaps and checks every
// result word against an in-bench tally of the timestamp ring.
// ----------------------------------------------------------------------------
// A short table of hand-picked words comes first. It covers reset, a zero
// window, an all-ones window, times below the window, stamps stored out of
// order, a full ring and the largest time. Eight random phases follow, each
// with its own window setting. Each result word is compared field by field
// with the oldest expected word.
// ----------------------------------------------------------------------------
module sliding_window_event_counter_tb;

    import swec_pkg::*;

    localparam int TW             = DEF_TIME_WIDTH;
    localparam int DEPTH          = DEF_STORE_DEPTH;
    localparam int CW             = $clog2(DEPTH + 1);
    localparam int N_PHASES       = 8;
    localparam int PHASE_WORDS    = 96;
    localparam int CALM_PHASE     = 4;
    localparam int DRAIN_PHASE    = 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int PRINT_LIMIT    = 20;

    localparam logic [TW-1:0] TIME_MAX = '1;

    // One result word as the block reports it.
    typedef struct packed {
        logic [TOTAL_WIDTH-1:0] total;
        logic [CW-1:0]          in_window;
        logic                   dropped;
    } t_tally;

    typedef enum logic { ROW_WORD, ROW_CFG } t_row_kind;

    // One row of the directed table. A word row is sent 'copies' times. A
    // config row writes 'window' once every result has come back. A row with
    // 'checked' set carries its own expected result.
    typedef struct {
        t_row_kind         kind;
        logic              op;
        logic [TW-1:0]     stamp;
        int unsigned       copies;
        logic [31:0]       window;
        bit                checked;
        t_tally            want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_operation;
    logic [TW-1:0]          i_now_time;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [WINDOW_WIDTH-1:0] i_window_ticks;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [TOTAL_WIDTH-1:0] o_total_events;
    logic [CW-1:0]          o_window_events;
    logic                   o_dropped_flag;

    sliding_window_event_counter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_now_time      (i_now_time),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_window_ticks  (i_window_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_total_events  (o_total_events),
        .o_window_events (o_window_events),
        .o_dropped_flag  (o_dropped_flag)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Our own copy of the ring, the running total and the window register.
    logic [TW-1:0]          ring_stamps [DEPTH];
    int                     ring_head;
    int                     ring_tail;
    int                     ring_fill;
    logic [TOTAL_WIDTH-1:0] ring_total;
    logic [31:0]            ring_window;

    // Expected result words, oldest first.
    t_tally pending_results [$];

    int  mismatches;
    int  words_sent;
    int  records_sent;
    int  windows_written;
    int  drops_seen;
    int  peak_in_window;
    int  quiet_cycles;
    bit  calm;

    // Directed table. The first three rows are plain enough to type in the
    // expected word; the rest rely on the tally.
    t_stim_row dir_table [21] = '{
        // Query straight after reset: nothing counted yet.
        '{ROW_WORD, OP_QUERY,  48'd0,            1, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b0}},
        '{ROW_WORD, OP_RECORD, 48'd0,            1, 32'd0, 1'b1, '{32'd1, 7'd1, 1'b0}},
        '{ROW_WORD, OP_RECORD, 48'd4999,         1, 32'd0, 1'b1, '{32'd2, 7'd2, 1'b0}},
        // Time below the window, then exactly at it: the stamp at 0 is evicted.
        '{ROW_WORD, OP_QUERY,  48'd4999,         1, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_QUERY,  48'd5000,         1, 32'd0, 1'b0, '0},
        // A stamp older than the one ahead of it stays while the newer one
        // blocks the eviction.
        '{ROW_WORD, OP_RECORD, 48'd3000,         1, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_QUERY,  48'd8500,         1, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_QUERY,  48'd9999,         1, 32'd0, 1'b0, '0},
        // A zero window acts as a window of one tick.
        '{ROW_CFG,  OP_RECORD, 48'd0,            0, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_RECORD, 48'd20000,        1, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_QUERY,  48'd20000,        1, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_QUERY,  48'd20001,        1, 32'd0, 1'b0, '0},
        // Largest window: times below it evict nothing, so the ring fills
        // and the next record drops its oldest stamp.
        '{ROW_CFG,  OP_RECORD, 48'd0,            0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WORD, OP_RECORD, 48'h1_0000_0000,  1, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_QUERY,  48'h0_FFFF_FFFE,  1, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_RECORD, 48'h0_0000_1000, 64, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_QUERY,  48'h1_0000_0000,  1, 32'd0, 1'b0, '0},
        '{ROW_WORD, OP_RECORD, 48'h1_0000_0FFF,  1, 32'd0, 1'b0, '0},
        '{ROW_CFG,  OP_RECORD, 48'd0,            0, 32'd1, 1'b0, '0},
        '{ROW_WORD, OP_RECORD, 48'h1_0000_0FFF,  1, 32'd0, 1'b0, '0},
        // The largest time clears the ring.
        '{ROW_WORD, OP_QUERY,  48'hFFFF_FFFF_FFFF, 1, 32'd0, 1'b0, '0}
    };

    // Apply one word to the tally and return the result the block owes.
    function automatic t_tally window_tally_step(input logic op, input logic [TW-1:0] now);
        longint unsigned span;
        logic [TW-1:0]   limit;
        t_tally          r;
        // A window of zero counts as one tick.
        span = (ring_window == '0) ? 64'd1 : 64'(ring_window);
        // Below the window nothing can be outdated. Otherwise pop from the
        // oldest end until a stamp newer than the limit is found.
        if (64'(now) >= span) begin
            limit = now - TW'(span);
            while (ring_fill > 0 && ring_stamps[ring_head] <= limit) begin
                ring_head = (ring_head + 1) % DEPTH;
                ring_fill--;
            end
        end
        r.dropped = 1'b0;
        if (op == OP_RECORD) begin
            ring_total = ring_total + 1'b1;
            if (ring_fill == DEPTH) begin
                ring_head = (ring_head + 1) % DEPTH;
                ring_fill--;
                r.dropped = 1'b1;
            end
            ring_stamps[ring_tail] = now;
            ring_tail = (ring_tail + 1) % DEPTH;
            ring_fill++;
        end
        r.total     = ring_total;
        r.in_window = CW'(ring_fill);
        return r;
    endfunction

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic flag_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
        end
        mismatches++;
    endtask

    // Lower the word valid and hold off until every result has come back.
    // Called at a falling edge.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Send one word. Called at a falling edge, returns at a falling edge with
    // valid still high, so that a back-to-back word needs no second
    // assignment in the same step.
    task automatic send_word(input logic op, input logic [TW-1:0] stamp,
                             input bit checked, input t_tally want);
        t_tally r;
        while (!calm && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_now_time  <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        r = window_tally_step(op, stamp);
        pending_results.push_back(checked ? want : r);
        words_sent++;
        if (op == OP_RECORD) begin
            records_sent++;
        end
        @(negedge i_clk);
    endtask

    // Write the window register once the block has gone idle.
    task automatic write_window(input logic [31:0] w);
        wait_drained();
        i_cfg_valid    <= 1'b1;
        i_window_ticks <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        ring_window = w;
        windows_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The receiver stalls about one cycle in five, except in the calm phase.
    always @(negedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    // Result checker: every accepted result word is matched against the
    // oldest expectation.
    always @(posedge i_clk) begin
        t_tally want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result word, total", o_total_events, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_total_events !== want.total) begin
                    flag_mismatch("total_events", o_total_events, want.total);
                end
                if (o_window_events !== want.in_window) begin
                    flag_mismatch("window_events", o_window_events, want.in_window);
                end
                if (o_dropped_flag !== want.dropped) begin
                    flag_mismatch("dropped_flag", o_dropped_flag, want.dropped);
                end
            end
            if (o_dropped_flag === 1'b1) begin
                drops_seen++;
            end
            if (int'(o_window_events) > peak_in_window) begin
                peak_in_window = int'(o_window_events);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0]     w;
        int              rec_pct;
        int              shift;
        longint unsigned span;
        longint unsigned base;
        longint unsigned top;
        longint unsigned now;
        longint unsigned back;
        int              pick;
        logic            op;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_operation     = OP_RECORD;
        i_now_time      = '0;
        i_cfg_valid     = 1'b0;
        i_window_ticks  = '0;
        i_out_ready     = 1'b0;
        calm            = 1'b0;
        mismatches      = 0;
        words_sent      = 0;
        records_sent    = 0;
        windows_written = 0;
        drops_seen      = 0;
        peak_in_window  = 0;
        quiet_cycles    = 0;
        ring_head       = 0;
        ring_tail       = 0;
        ring_fill       = 0;
        ring_total      = '0;
        ring_window     = WINDOW_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part.
        foreach (dir_table[k]) begin
            if (dir_table[k].kind == ROW_CFG) begin
                write_window(dir_table[k].window);
            end else begin
                for (int c = 0; c < dir_table[k].copies; c++) begin
                    send_word(dir_table[k].op, dir_table[k].stamp,
                              dir_table[k].checked, dir_table[k].want);
                end
            end
        end

        // Random part. Each phase gets its own window, record ratio and time
        // step scale, and lives in its own slice of the time range, so that
        // time mostly moves forward. Steps are drawn relative to the window:
        // bursts at one time, small steps that keep many stamps alive, jumps
        // that clear the ring, and a few steps backward.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            unique case (ph)
                0: begin
                    w = $urandom_range(1, 64);     rec_pct = 65; shift = 3;
                end
                1: begin
                    w = 32'd0;                     rec_pct = 60; shift = 0;
                end
                2: begin
                    w = 32'hFFFF_FFFF;             rec_pct = 85; shift = 12;
                end
                3: begin
                    w = $urandom;                  rec_pct = 60; shift = 3;
                end
                4: begin
                    w = $urandom_range(100, 5000); rec_pct = 70; shift = 4;
                end
                5: begin
                    w = WINDOW_RESET;              rec_pct = 75; shift = 6;
                end
                6: begin
                    w = $urandom_range(1, 8);      rec_pct = 60; shift = 1;
                end
                default: begin
                    w = $urandom;                  rec_pct = 90; shift = 10;
                end
            endcase
            write_window(w);
            // One phase runs with neither side ever stalling.
            calm = (ph == CALM_PHASE);
            span = (w == '0) ? 64'd1 : 64'(w);
            base = (64'(ph) << 45) + (rand64() % (64'd1 << 44));
            top  = base + (64'd1 << 45) - 1;
            now  = base;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                // Halfway through one phase the sender waits for every result.
                if (ph == DRAIN_PHASE && i == PHASE_WORDS / 2) begin
                    wait_drained();
                end
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    // Same time as the previous word.
                end else if (pick < 75) begin
                    now = now + rand64() % ((span >> shift) + 2);
                end else if (pick < 92) begin
                    now = now + rand64() % (2 * span + 2);
                end else begin
                    back = rand64() % ((span >> 2) + 2);
                    now  = (now - base > back) ? now - back : base;
                end
                if (now > top) begin
                    now = top;
                end
                op = ($urandom_range(0, 99) < rec_pct) ? OP_RECORD : OP_QUERY;
                send_word(op, TW'(now), 1'b0, '0);
            end
        end
        calm = 1'b0;

        // Stamps at the largest time can never leave the ring, so they come
        // last.
        send_word(OP_RECORD, TIME_MAX, 1'b0, '0);
        send_word(OP_RECORD, TIME_MAX, 1'b0, '0);
        send_word(OP_QUERY,  TIME_MAX, 1'b0, '0);

        wait_drained();
        // Stay a while longer so that a stray extra result word is caught.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d records, %0d queries) under %0d window settings.",
                 words_sent, records_sent, words_sent - records_sent, windows_written);
        $display("Saw %0d full-ring drops, peak in-window count %0d, %0d mismatches.",
                 drops_seen, peak_in_window, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
